/* hw/rtl/mcs_pkg.sv */
// Shared types and constants for the min/max contrast stretch block.
package mcs_pkg;

   // The stretched result is always an 8-bit level; the full scale is 2^8 - 1.
   localparam int unsigned OUT_BITS  = 8;
   localparam logic [OUT_BITS-1:0] OUT_SCALE = {OUT_BITS{1'b1}};

   // The quotient of a stretch is below full scale, so it needs OUT_BITS steps.
   localparam int unsigned QUOT_BITS = OUT_BITS;
   localparam int unsigned CNT_BITS  = $clog2(QUOT_BITS);

   // Encoding of the action field.
   localparam logic ACTION_MEASURE = 1'b0;
   localparam logic ACTION_STRETCH = 1'b1;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept_measure;
      logic accept_stretch;
      logic setup;
      logic div_step;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic special;
      logic out_free;
   } status_type;

endpackage

/* hw/rtl/mcs_ctrl.sv */
// Controller state machine for the min/max contrast stretch block.
module mcs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   output logic                req_ready,
   input  mcs_pkg::status_type status,
   output mcs_pkg::cmd_type    cmd
);

   mcs_pkg::state_type             state_ff, state_in;
   logic [mcs_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcs_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mcs_pkg::ST_IDLE: begin
            // Measure transfers finish here; a stretch transfer starts the sequence.
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == mcs_pkg::ACTION_STRETCH) begin
                  cmd.accept_stretch = 1'b1;
                  state_in = mcs_pkg::ST_SETUP;
               end else begin
                  cmd.accept_measure = 1'b1;
               end
            end
         end
         mcs_pkg::ST_SETUP: begin
            // Saturated and flat cases skip the divider.
            cmd.setup = 1'b1;
            cnt_in    = '0;
            state_in  = status.special ? mcs_pkg::ST_DONE : mcs_pkg::ST_DIVIDE;
         end
         mcs_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mcs_pkg::CNT_BITS'(mcs_pkg::QUOT_BITS - 1)) begin
               state_in = mcs_pkg::ST_DONE;
            end
         end
         mcs_pkg::ST_DONE: begin
            // Wait until the output register can take the result.
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = mcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/mcs_datapath.sv */
// Datapath: min/max statistics, stretch setup, radix-2 divider and output register.
module mcs_datapath #(
   parameter int unsigned PIXEL_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [PIXEL_BITS-1:0]         req_pixel,
   input  logic                          req_new_frame,
   input  mcs_pkg::cmd_type              cmd,
   output mcs_pkg::status_type           status,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [mcs_pkg::OUT_BITS-1:0]  rsp_stretched,
   output logic                          rsp_flat_range
);

   localparam int unsigned WIDE_BITS = PIXEL_BITS + mcs_pkg::OUT_BITS;

   logic [PIXEL_BITS-1:0]            min_ff, min_in;
   logic [PIXEL_BITS-1:0]            max_ff, max_in;
   logic [PIXEL_BITS-1:0]            pix_ff, pix_in;
   logic [WIDE_BITS-1:0]             rem_ff, rem_in;
   logic [WIDE_BITS-1:0]             div_ff, div_in;
   logic [mcs_pkg::QUOT_BITS-1:0]    quot_ff, quot_in;
   logic                             special_ff, special_in;
   logic                             flat_ff, flat_in;
   logic [mcs_pkg::OUT_BITS-1:0]     sat_ff, sat_in;
   logic                             out_valid_ff, out_valid_in;
   logic [mcs_pkg::OUT_BITS-1:0]     out_data_ff, out_data_in;
   logic                             out_flat_ff, out_flat_in;

   logic [PIXEL_BITS-1:0]            base_min, base_max;
   logic [PIXEL_BITS-1:0]            span, diff;
   logic                             is_flat, is_low, is_high;
   logic [WIDE_BITS-1:0]             diff_wide;

   // Case detection on the captured pixel against the current statistics.
   assign is_flat   = !(max_ff > min_ff);
   assign is_low    = (pix_ff <= min_ff);
   assign is_high   = (pix_ff >= max_ff);
   assign span      = max_ff - min_ff;
   assign diff      = pix_ff - min_ff;
   assign diff_wide = WIDE_BITS'(diff);

   assign status.special  = is_flat || is_low || is_high;
   assign status.out_free = !out_valid_ff || rsp_ready;

   // Statistics update; a new frame restarts them before the pixel is folded in.
   always_comb begin
      base_min = req_new_frame ? {PIXEL_BITS{1'b1}} : min_ff;
      base_max = req_new_frame ? '0 : max_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (cmd.accept_measure) begin
         min_in = (req_pixel < base_min) ? req_pixel : base_min;
         max_in = (req_pixel > base_max) ? req_pixel : base_max;
      end
   end

   // Setup and restoring division of (pixel - min) * 255 by (max - min).
   always_comb begin
      pix_in     = cmd.accept_stretch ? req_pixel : pix_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      quot_in    = quot_ff;
      special_in = special_ff;
      flat_in    = flat_ff;
      sat_in     = sat_ff;
      if (cmd.setup) begin
         // Multiplying by 2^8 - 1 is a shift and a subtract.
         rem_in     = (diff_wide << mcs_pkg::OUT_BITS) - diff_wide;
         div_in     = WIDE_BITS'(span) << (mcs_pkg::QUOT_BITS - 1);
         quot_in    = '0;
         special_in = is_flat || is_low || is_high;
         flat_in    = is_flat;
         sat_in     = (!is_flat && !is_low) ? mcs_pkg::OUT_SCALE : '0;
      end else if (cmd.div_step) begin
         if (rem_ff >= div_ff) begin
            rem_in  = rem_ff - div_ff;
            quot_in = {quot_ff[mcs_pkg::QUOT_BITS-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[mcs_pkg::QUOT_BITS-2:0], 1'b0};
         end
         div_in = div_ff >> 1;
      end
   end

   // Output register; a new result may load in the cycle the old one transfers.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_flat_in  = out_flat_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_data_in  = special_ff ? sat_ff : quot_ff;
         out_flat_in  = flat_ff;
      end else if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= {PIXEL_BITS{1'b1}};
         max_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         min_ff       <= min_in;
         max_ff       <= max_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quot_ff     <= quot_in;
      special_ff  <= special_in;
      flat_ff     <= flat_in;
      sat_ff      <= sat_in;
      out_data_ff <= out_data_in;
      out_flat_ff <= out_flat_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_stretched  = out_data_ff;
   assign rsp_flat_range = out_flat_ff;

endmodule

/* hw/rtl/minmax_contrast_stretch.sv */
// Min/max contrast stretch: measure pixels into min/max, stretch pixels to 0..255.
// Measure items may follow every cycle while no stretch is in progress; they give no result.
// A stretch item is divided by a radix-2 restoring divider, one quotient bit per cycle;
// no new item is taken until its result loads into the output register, which waits
// for a free output. A flat range or a saturating pixel skips the divider.
// Synchronous reset sets min to all ones, max to zero and empties the output register.
module minmax_contrast_stretch #(
   parameter int unsigned PIXEL_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [PIXEL_BITS-1:0]         req_pixel,
   input  logic                          req_new_frame,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mcs_pkg::OUT_BITS-1:0]  rsp_stretched,
   output logic                          rsp_flat_range
);

   mcs_pkg::cmd_type    cmd;
   mcs_pkg::status_type status;

   mcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   mcs_datapath #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_pixel      (req_pixel),
      .req_new_frame  (req_new_frame),
      .cmd            (cmd),
      .status         (status),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stretched  (rsp_stretched),
      .rsp_flat_range (rsp_flat_range)
   );

   // A flat range always gives a zero level.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flat_range) |-> (rsp_stretched == '0))
      else $error("flat range result is not zero");

   // A stretch transfer blocks the input until its result is loaded.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_action == mcs_pkg::ACTION_STRETCH)) |=> !req_ready)
      else $error("input ready right after a stretch transfer");

   // A new result never overwrites one that has not been transferred.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output register overwritten");

   // The divider never runs while the input side is open.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step || cmd.setup) |-> !req_ready)
      else $error("input ready during a stretch");

endmodule
